/* design/skbt_pkg.sv */
// Shared constants, codes and types for the sorted key bucket table.
// Used by skbt_ctrl, skbt_dpath and sorted_key_bucket_table; depends on nothing.
`default_nettype none

package skbt_pkg;

    localparam int KEY_SLOTS    = 64;
    localparam int BUCKET_DEPTH = 16;
    localparam int ITEM_BITS    = 10;

    localparam int KEY_BITS     = 32;
    localparam int OP_BITS      = 2;
    localparam int STATUS_BITS  = 2;
    localparam int SLOT_BITS    = $clog2(KEY_SLOTS);
    localparam int CNT_BITS     = $clog2(KEY_SLOTS + 1);
    localparam int IDX_BITS     = $clog2(KEY_SLOTS + 3);
    localparam int MEMBER_BITS  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int SIZE_BITS    = $clog2(BUCKET_DEPTH + 1);
    localparam int MEMBER_DEPTH = KEY_SLOTS << MEMBER_BITS;

    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_READ   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_TABLE_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_BUCKET_FULL = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_RANGE       = 2'd3;

    localparam int KIND_BITS = 3;
    localparam logic [KIND_BITS-1:0] KIND_ZERO     = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_APPEND   = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_BFULL    = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_TFULL    = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_NEW      = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_RD_SLOT  = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_RD_MEM   = 3'd6;
    localparam logic [KIND_BITS-1:0] KIND_RD_OK    = 3'd7;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [SIZE_BITS-1:0] size;
        logic [SLOT_BITS-1:0] phys;
    } t_slot_entry;

    typedef struct packed {
        logic                 start;
        logic                 clear;
        logic                 scan;
        logic                 latch_hit;
        logic                 append;
        logic                 shift_init;
        logic                 shift;
        logic                 place;
        logic                 rd_slot;
        logic                 rd_member;
        logic                 load;
        logic [KIND_BITS-1:0] kind;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic bucket_full;
        logic table_full;
        logic shift_done;
        logic rd_slot_oor;
        logic rd_mem_oor;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

/* design/sorted_key_bucket_table.sv */
// Top level of the sorted key bucket table: controller plus datapath.
// Depends on skbt_pkg, skbt_ctrl and skbt_dpath.
//
//   channel   handshake              payload
//   request   i_valid / o_ready      i_operation i_key i_item_index i_read_slot i_read_member
//   result    o_valid / i_ready      o_status o_slot o_created_new o_member_count
//                                    o_key_count o_read_key o_read_item
//
// One beat at a time.
// Insert: scan of the slot memory, one slot per cycle, up to the sorted position; a held key
// then appends to its bucket unless it is full, a full table ends the insert, and a new key
// first shifts each later slot entry up by one, then is placed at its sorted position.
// Read checks the slot range, reads the slot, then the member; clear empties the table.
// Buckets stay in place; slots keep a bucket pointer, so only slot entries move.
// Reset empties the table; memory contents need no clearing.
// A result held on o_valid stalls only the next completion, not the next request.
`default_nettype none

module sorted_key_bucket_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [skbt_pkg::OP_BITS-1:0]     i_operation,
    input  logic [skbt_pkg::KEY_BITS-1:0]    i_key,
    input  logic [skbt_pkg::ITEM_BITS-1:0]   i_item_index,
    input  logic [skbt_pkg::SLOT_BITS-1:0]   i_read_slot,
    input  logic [skbt_pkg::MEMBER_BITS-1:0] i_read_member,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [skbt_pkg::STATUS_BITS-1:0] o_status,
    output logic [skbt_pkg::SLOT_BITS-1:0]   o_slot,
    output logic                             o_created_new,
    output logic [skbt_pkg::SIZE_BITS-1:0]   o_member_count,
    output logic [skbt_pkg::CNT_BITS-1:0]    o_key_count,
    output logic [skbt_pkg::KEY_BITS-1:0]    o_read_key,
    output logic [skbt_pkg::ITEM_BITS-1:0]   o_read_item
);
    import skbt_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    skbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    skbt_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_key          (i_key),
        .i_item_index   (i_item_index),
        .i_read_slot    (i_read_slot),
        .i_read_member  (i_read_member),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_created_new  (o_created_new),
        .o_member_count (o_member_count),
        .o_key_count    (o_key_count),
        .o_read_key     (o_read_key),
        .o_read_item    (o_read_item)
    );

endmodule

`default_nettype wire

/* design/skbt_ctrl.sv */
// Controller state machine of the sorted key bucket table.
// Sequences scan, shift, place and read steps; depends on skbt_pkg.
`default_nettype none

module skbt_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [skbt_pkg::OP_BITS-1:0]  i_operation,
    input  skbt_pkg::t_dp_sts             i_sts,
    output skbt_pkg::t_dp_cmd             o_cmd
);
    import skbt_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN     = 4'd1;
    localparam logic [3:0] S_DECIDE   = 4'd2;
    localparam logic [3:0] S_SHIFT    = 4'd3;
    localparam logic [3:0] S_PLACE    = 4'd4;
    localparam logic [3:0] S_RD_CHECK = 4'd5;
    localparam logic [3:0] S_RD_SLOT  = 4'd6;
    localparam logic [3:0] S_RD_MEM   = 4'd7;
    localparam logic [3:0] S_FINISH   = 4'd8;

    logic [3:0]           r_state, n_state;
    logic [KIND_BITS-1:0] r_kind, n_kind;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.kind = r_kind;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    unique case (i_operation)
                        OP_INSERT: n_state = S_SCAN;
                        OP_READ:   n_state = S_RD_CHECK;
                        OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            n_kind      = KIND_ZERO;
                            n_state     = S_FINISH;
                        end
                        default: begin
                            n_kind  = KIND_ZERO;
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.latch_hit = 1'b1;
                    n_state         = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.found) begin
                    if (i_sts.bucket_full) begin
                        n_kind = KIND_BFULL;
                    end else begin
                        o_cmd.append = 1'b1;
                        n_kind       = KIND_APPEND;
                    end
                    n_state = S_FINISH;
                end else if (i_sts.table_full) begin
                    n_kind  = KIND_TFULL;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.shift_done) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_kind      = KIND_NEW;
                n_state     = S_FINISH;
            end
            S_RD_CHECK: begin
                if (i_sts.rd_slot_oor) begin
                    n_kind  = KIND_RD_SLOT;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.rd_slot = 1'b1;
                    n_state       = S_RD_SLOT;
                end
            end
            S_RD_SLOT: begin
                o_cmd.rd_member = 1'b1;
                if (i_sts.rd_mem_oor) begin
                    n_kind  = KIND_RD_MEM;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_RD_MEM;
                end
            end
            S_RD_MEM: begin
                n_kind  = KIND_RD_OK;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_ZERO;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

`default_nettype wire

/* design/skbt_dpath.sv */
// Datapath of the sorted key bucket table: slot memory, bucket member memory,
// scan and shift counters, key count and the result register; depends on skbt_pkg.
`default_nettype none

module skbt_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  skbt_pkg::t_dp_cmd                i_cmd,
    output skbt_pkg::t_dp_sts                o_sts,
    input  logic [skbt_pkg::KEY_BITS-1:0]    i_key,
    input  logic [skbt_pkg::ITEM_BITS-1:0]   i_item_index,
    input  logic [skbt_pkg::SLOT_BITS-1:0]   i_read_slot,
    input  logic [skbt_pkg::MEMBER_BITS-1:0] i_read_member,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [skbt_pkg::STATUS_BITS-1:0] o_status,
    output logic [skbt_pkg::SLOT_BITS-1:0]   o_slot,
    output logic                             o_created_new,
    output logic [skbt_pkg::SIZE_BITS-1:0]   o_member_count,
    output logic [skbt_pkg::CNT_BITS-1:0]    o_key_count,
    output logic [skbt_pkg::KEY_BITS-1:0]    o_read_key,
    output logic [skbt_pkg::ITEM_BITS-1:0]   o_read_item
);
    import skbt_pkg::*;

    localparam int MADDR_BITS = SLOT_BITS + MEMBER_BITS;

    t_slot_entry             r_slot_mem [KEY_SLOTS];
    logic [ITEM_BITS-1:0]    r_member_mem [MEMBER_DEPTH];

    logic [KEY_BITS-1:0]     r_key;
    logic [ITEM_BITS-1:0]    r_item;
    logic [SLOT_BITS-1:0]    r_in_slot;
    logic [MEMBER_BITS-1:0]  r_in_member;
    logic [CNT_BITS-1:0]     r_count;
    logic [IDX_BITS-1:0]     r_idx;
    logic [IDX_BITS-1:0]     r_rd_idx;
    logic [IDX_BITS-1:0]     r_pos;
    t_slot_entry             r_rd;
    t_slot_entry             r_ent;
    logic                    r_found;
    logic                    r_scan_live;
    logic                    r_sh_pend;
    logic [SLOT_BITS-1:0]    r_sh_addr;
    logic [ITEM_BITS-1:0]    r_item_rd;

    logic                    r_out_valid;
    logic [STATUS_BITS-1:0]  r_status;
    logic [SLOT_BITS-1:0]    r_slot;
    logic                    r_created;
    logic [SIZE_BITS-1:0]    r_mcount;
    logic [CNT_BITS-1:0]     r_kcount;
    logic [KEY_BITS-1:0]     r_rkey;
    logic [ITEM_BITS-1:0]    r_ritem;

    logic [IDX_BITS-1:0]     idx_dec;
    logic                    shift_go;
    logic                    rd_in;
    logic                    hit_eq;
    logic [SIZE_BITS-1:0]    size_inc;
    logic [SLOT_BITS-1:0]    slot_rd_addr;
    logic                    slot_wr_en;
    logic [SLOT_BITS-1:0]    slot_wr_addr;
    t_slot_entry             slot_wr_data;
    logic                    mem_wr_en;
    logic [MADDR_BITS-1:0]   mem_wr_addr;
    logic [MADDR_BITS-1:0]   mem_rd_addr;

    logic [STATUS_BITS-1:0]  res_status;
    logic [SLOT_BITS-1:0]    res_slot;
    logic                    res_created;
    logic [SIZE_BITS-1:0]    res_mcount;
    logic [KEY_BITS-1:0]     res_rkey;
    logic [ITEM_BITS-1:0]    res_ritem;

    assign idx_dec  = r_idx - 1'b1;
    assign shift_go = i_cmd.shift && (r_idx > r_pos);
    assign rd_in    = r_rd_idx < IDX_BITS'(r_count);
    assign hit_eq   = rd_in && (r_rd.key == r_key);
    assign size_inc = r_ent.size + 1'b1;

    assign o_sts.scan_done   = r_scan_live && (!rd_in || (r_rd.key >= r_key));
    assign o_sts.found       = r_found;
    assign o_sts.bucket_full = r_ent.size >= SIZE_BITS'(BUCKET_DEPTH);
    assign o_sts.table_full  = r_count >= CNT_BITS'(KEY_SLOTS);
    assign o_sts.shift_done  = (r_idx == r_pos) && !r_sh_pend;
    assign o_sts.rd_slot_oor = CNT_BITS'(r_in_slot) >= r_count;
    assign o_sts.rd_mem_oor  = SIZE_BITS'(r_in_member) >= r_rd.size;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        if (i_cmd.shift) begin
            slot_rd_addr = idx_dec[SLOT_BITS-1:0];
        end else if (i_cmd.rd_slot) begin
            slot_rd_addr = r_in_slot;
        end else begin
            slot_rd_addr = r_idx[SLOT_BITS-1:0];
        end
    end

    always_comb begin
        slot_wr_en   = 1'b0;
        slot_wr_addr = r_pos[SLOT_BITS-1:0];
        slot_wr_data = r_rd;
        if (r_sh_pend) begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = r_sh_addr;
        end else if (i_cmd.append) begin
            slot_wr_en        = 1'b1;
            slot_wr_data      = r_ent;
            slot_wr_data.size = size_inc;
        end else if (i_cmd.place) begin
            slot_wr_en        = 1'b1;
            slot_wr_data.key  = r_key;
            slot_wr_data.size = SIZE_BITS'(1);
            slot_wr_data.phys = r_count[SLOT_BITS-1:0];
        end
    end

    always_comb begin
        mem_wr_en   = i_cmd.append || i_cmd.place;
        mem_wr_addr = {r_ent.phys, r_ent.size[MEMBER_BITS-1:0]};
        if (i_cmd.place) begin
            mem_wr_addr = {r_count[SLOT_BITS-1:0], MEMBER_BITS'(0)};
        end
        mem_rd_addr = {r_ent.phys, r_in_member};
    end

    always_ff @(posedge i_clk) begin
        if (slot_wr_en) begin
            r_slot_mem[slot_wr_addr] <= slot_wr_data;
        end
        r_rd <= r_slot_mem[slot_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_member_mem[mem_wr_addr] <= r_item;
        end
        r_item_rd <= r_member_mem[mem_rd_addr];
    end

    always_comb begin
        res_status  = ST_OK;
        res_slot    = '0;
        res_created = 1'b0;
        res_mcount  = '0;
        res_rkey    = '0;
        res_ritem   = '0;
        unique case (i_cmd.kind)
            KIND_APPEND: begin
                res_slot   = r_pos[SLOT_BITS-1:0];
                res_mcount = r_ent.size;
            end
            KIND_BFULL: begin
                res_status = ST_BUCKET_FULL;
                res_slot   = r_pos[SLOT_BITS-1:0];
                res_mcount = r_ent.size;
            end
            KIND_TFULL: begin
                res_status = ST_TABLE_FULL;
            end
            KIND_NEW: begin
                res_slot    = r_pos[SLOT_BITS-1:0];
                res_created = 1'b1;
                res_mcount  = SIZE_BITS'(1);
            end
            KIND_RD_SLOT: begin
                res_status = ST_RANGE;
                res_slot   = r_in_slot;
            end
            KIND_RD_MEM: begin
                res_status = ST_RANGE;
                res_slot   = r_in_slot;
                res_mcount = r_ent.size;
                res_rkey   = r_ent.key;
            end
            KIND_RD_OK: begin
                res_slot   = r_in_slot;
                res_mcount = r_ent.size;
                res_rkey   = r_ent.key;
                res_ritem  = r_item_rd;
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key       <= i_key;
            r_item      <= i_item_index;
            r_in_slot   <= i_read_slot;
            r_in_member <= i_read_member;
        end
        priority if (i_cmd.start) begin
            r_idx <= '0;
        end else if (i_cmd.shift_init) begin
            r_idx <= IDX_BITS'(r_count);
        end else if (shift_go) begin
            r_idx <= idx_dec;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + 1'b1;
        end
        r_rd_idx  <= r_idx;
        r_sh_addr <= r_idx[SLOT_BITS-1:0];
        if (i_cmd.latch_hit) begin
            r_pos   <= r_rd_idx;
            r_ent   <= r_rd;
            r_found <= hit_eq;
        end else if (i_cmd.append) begin
            r_ent.size <= size_inc;
        end else if (i_cmd.rd_member) begin
            r_ent <= r_rd;
        end
        if (i_cmd.load) begin
            r_status <= res_status;
            r_slot   <= res_slot;
            r_created <= res_created;
            r_mcount <= res_mcount;
            r_kcount <= r_count;
            r_rkey   <= res_rkey;
            r_ritem  <= res_ritem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_scan_live <= 1'b0;
            r_sh_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.place) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.start) begin
                r_scan_live <= 1'b0;
            end else if (i_cmd.scan) begin
                r_scan_live <= 1'b1;
            end
            r_sh_pend <= shift_go;
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_slot         = r_slot;
    assign o_created_new  = r_created;
    assign o_member_count = r_mcount;
    assign o_key_count    = r_kcount;
    assign o_read_key     = r_rkey;
    assign o_read_item    = r_ritem;

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// Testbench for sorted_key_bucket_table: directed and random insert, read and clear beats.
// A scoreboard class tracks the sorted key table and checks every result beat in order.
// Depends on skbt_pkg and the sorted_key_bucket_table RTL.

module tb;
    import skbt_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 150;
    localparam int PHASE_BEATS  = 345;
    localparam int FILL_BEATS   = 70;
    localparam int POOL_SIZE    = 128;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [SLOT_BITS-1:0]   slot;
        logic                   created_new;
        logic [SIZE_BITS-1:0]   member_count;
        logic [CNT_BITS-1:0]    key_count;
        logic [KEY_BITS-1:0]    read_key;
        logic [ITEM_BITS-1:0]   read_item;
    } t_table_result;

    class key_table_tracker;
        logic [KEY_BITS-1:0]  keys [KEY_SLOTS];
        logic [SIZE_BITS-1:0] sizes [KEY_SLOTS];
        logic [ITEM_BITS-1:0] members [KEY_SLOTS][BUCKET_DEPTH];
        int                   held;
        t_table_result        expected_results [$];
        int                   errors;

        function new();
            held   = 0;
            errors = 0;
            for (int s = 0; s < KEY_SLOTS; s++) begin
                keys[s]  = '0;
                sizes[s] = '0;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_request(logic [OP_BITS-1:0] op, logic [KEY_BITS-1:0] key,
                                   logic [ITEM_BITS-1:0] item,
                                   logic [SLOT_BITS-1:0] rslot,
                                   logic [MEMBER_BITS-1:0] rmem);
            t_table_result r;
            int            hit;
            int            pos;
            r   = '0;
            hit = -1;
            case (op)
                OP_INSERT: begin
                    for (int i = 0; i < held; i++) begin
                        if (keys[i] == key) hit = i;
                    end
                    if (hit >= 0) begin
                        r.slot = SLOT_BITS'(hit);
                        if (sizes[hit] >= BUCKET_DEPTH) begin
                            r.status = ST_BUCKET_FULL;
                        end else begin
                            members[hit][sizes[hit]] = item;
                            sizes[hit] = sizes[hit] + 1'b1;
                        end
                        r.member_count = sizes[hit];
                    end else if (held >= KEY_SLOTS) begin
                        r.status = ST_TABLE_FULL;
                    end else begin
                        pos = 0;
                        while (pos < held && keys[pos] < key) pos++;
                        for (int j = held; j > pos; j--) begin
                            keys[j]  = keys[j-1];
                            sizes[j] = sizes[j-1];
                            for (int m = 0; m < BUCKET_DEPTH; m++)
                                members[j][m] = members[j-1][m];
                        end
                        keys[pos]       = key;
                        sizes[pos]      = 1;
                        members[pos][0] = item;
                        held++;
                        r.slot         = SLOT_BITS'(pos);
                        r.created_new  = 1'b1;
                        r.member_count = 1;
                    end
                end
                OP_READ: begin
                    r.slot = rslot;
                    if (rslot >= held) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.member_count = sizes[rslot];
                        r.read_key     = keys[rslot];
                        if (rmem >= sizes[rslot])
                            r.status = ST_RANGE;
                        else
                            r.read_item = members[rslot][rmem];
                    end
                end
                OP_CLEAR: begin
                    held = 0;
                end
                default: ;
            endcase
            r.key_count = CNT_BITS'(held);
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_table_result got);
            t_table_result want;
            if (expected_results.size() == 0) begin
                $error("result beat with no request pending");
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("slot", 32'(want.slot), 32'(got.slot));
            compare_field("created_new", 32'(want.created_new), 32'(got.created_new));
            compare_field("member_count", 32'(want.member_count), 32'(got.member_count));
            compare_field("key_count", 32'(want.key_count), 32'(got.key_count));
            compare_field("read_key", 32'(want.read_key), 32'(got.read_key));
            compare_field("read_item", 32'(want.read_item), 32'(got.read_item));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [OP_BITS-1:0]     i_operation = OP_CLEAR;
    logic [KEY_BITS-1:0]    i_key = '0;
    logic [ITEM_BITS-1:0]   i_item_index = '0;
    logic [SLOT_BITS-1:0]   i_read_slot = '0;
    logic [MEMBER_BITS-1:0] i_read_member = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [STATUS_BITS-1:0] o_status;
    logic [SLOT_BITS-1:0]   o_slot;
    logic                   o_created_new;
    logic [SIZE_BITS-1:0]   o_member_count;
    logic [CNT_BITS-1:0]    o_key_count;
    logic [KEY_BITS-1:0]    o_read_key;
    logic [ITEM_BITS-1:0]   o_read_item;

    key_table_tracker    table_sb;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  ready_hold_left = 0;
    int                  cycle_count = 0;
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

    sorted_key_bucket_table DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_key          (i_key),
        .i_item_index   (i_item_index),
        .i_read_slot    (i_read_slot),
        .i_read_member  (i_read_member),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_created_new  (o_created_new),
        .o_member_count (o_member_count),
        .o_key_count    (o_key_count),
        .o_read_key     (o_read_key),
        .o_read_item    (o_read_item)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // hold ready low during a requested hold-off, else stall at the phase rate
    always @(negedge i_clk) begin
        if (ready_hold_left > 0) begin
            i_ready <= 1'b0;
            ready_hold_left <= ready_hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            table_sb.check_result({o_status, o_slot, o_created_new, o_member_count,
                                   o_key_count, o_read_key, o_read_item});
    end

    task automatic send_beat(input logic [OP_BITS-1:0] op, input logic [KEY_BITS-1:0] key,
                             input logic [ITEM_BITS-1:0] item,
                             input logic [SLOT_BITS-1:0] rslot,
                             input logic [MEMBER_BITS-1:0] rmem);
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_key         <= key;
        i_item_index  <= item;
        i_read_slot   <= rslot;
        i_read_member <= rmem;
        do @(posedge i_clk); while (!o_ready);
        table_sb.note_request(op, key, item, rslot, rmem);
    endtask

    task automatic sender_idle();
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(90, 10) : $urandom_range(3, 1);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (table_sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic insert_beat(input logic [KEY_BITS-1:0] key, input logic [ITEM_BITS-1:0] item);
        send_beat(OP_INSERT, key, item, SLOT_BITS'($urandom), MEMBER_BITS'($urandom));
    endtask

    task automatic read_beat(input logic [SLOT_BITS-1:0] rslot,
                             input logic [MEMBER_BITS-1:0] rmem);
        send_beat(OP_READ, $urandom, ITEM_BITS'($urandom), rslot, rmem);
    endtask

    task automatic clear_beat();
        send_beat(OP_CLEAR, $urandom, ITEM_BITS'($urandom), SLOT_BITS'($urandom),
                  MEMBER_BITS'($urandom));
    endtask

    task automatic directed_beats();
        read_beat(0, 0);
        clear_beat();
        insert_beat(32'h8000_0000, 0);
        insert_beat(32'h0000_0000, 10'h3FF);
        insert_beat(32'hFFFF_FFFF, 10'h200);
        insert_beat(32'h0000_0000, 10'h005);
        read_beat(0, 1);
        read_beat(0, 2);
        read_beat(2, 0);
        read_beat(3, 0);
        read_beat(SLOT_BITS'(KEY_SLOTS - 1), MEMBER_BITS'(BUCKET_DEPTH - 1));
        for (int n = 2; n <= BUCKET_DEPTH; n++)
            insert_beat(32'h0000_0000, ITEM_BITS'($urandom));
        read_beat(0, MEMBER_BITS'(BUCKET_DEPTH - 1));
        clear_beat();
        read_beat(0, 0);
    endtask

    task automatic random_beat(input int pool_n, input int clear_pm);
        int                   pick;
        int                   held;
        logic [KEY_BITS-1:0]  key;
        logic [SLOT_BITS-1:0] rslot;
        logic [MEMBER_BITS-1:0] rmem;
        pick = $urandom_range(999);
        held = table_sb.held;
        key  = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(pool_n - 1)];
        if (pick < clear_pm) begin
            clear_beat();
        end else if (pick < clear_pm + 370) begin
            if ($urandom_range(4) == 0)
                rslot = SLOT_BITS'($urandom);
            else
                rslot = SLOT_BITS'($urandom_range(held > KEY_SLOTS - 1 ? KEY_SLOTS - 1 : held));
            if (rslot < held && $urandom_range(4) != 0)
                rmem = MEMBER_BITS'($urandom_range(table_sb.sizes[rslot] > BUCKET_DEPTH - 1 ?
                                                   BUCKET_DEPTH - 1 : table_sb.sizes[rslot]));
            else
                rmem = MEMBER_BITS'($urandom);
            read_beat(rslot, rmem);
        end else begin
            insert_beat(key, ITEM_BITS'($urandom));
        end
    endtask

    initial begin
        int pool_n;
        int clear_pm;
        table_sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_beats();
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  pool_n = 6;   clear_pm = 5;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  pool_n = 100; clear_pm = 5;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; pool_n = 40;  clear_pm = 15; end
                default: begin
                    send_idle_pct = 38; recv_stall_pct = 38; pool_n = 100; clear_pm = 15;
                end
            endcase
            for (int p = 0; p < POOL_SIZE; p++)
                key_pool[p] = $urandom;
            key_pool[0] = '0;
            key_pool[1] = '1;
            key_pool[2] = 32'h0000_0001;
            key_pool[3] = 32'hFFFF_FFFE;
            if (phase == 1 || phase == 3) begin
                clear_beat();
                for (int f = 0; f < FILL_BEATS; f++) begin
                    sender_idle();
                    insert_beat($urandom, ITEM_BITS'($urandom));
                end
            end
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (phase == 0 && n == 150)
                    ready_hold_left = 400;
                sender_idle();
                random_beat(pool_n, clear_pm);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (table_sb.errors == 0 && table_sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
